[rtl/core/tdst_pkg.sv]
// shared types and constants for the task delay state table
`timescale 1ns / 1ps

package tdst_pkg;

  localparam int IN_W     = 32;
  localparam int OUT_W    = 24;
  localparam int CMD_W    = 3;
  localparam int TASK_W   = 4;
  localparam int NSTATE_W = 6;
  localparam int TIME_W   = 16;
  localparam int STATE_W  = 8;
  localparam int ENTRY_W  = STATE_W + TIME_W;

  localparam logic [STATE_W-1:0] FLAG_DELAYING = 8'h80;
  localparam logic [STATE_W-1:0] FLAG_INSTATE  = 8'h40;
  localparam logic [STATE_W-1:0] FLAG_MASK     = 8'hC0;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK         = 3'd0,
    CMD_READ         = 3'd1,
    CMD_MARK_INSTATE = 3'd2,
    CMD_GOTO         = 3'd3,
    CMD_GOTO_FORCED  = 3'd4,
    CMD_DELAY        = 3'd5,
    CMD_DELAY_FORCED = 3'd6
  } cmd_e;

  typedef struct packed {
    logic cmd_ld;
    logic scan_clr;
    logic scan_rd;
    logic cmd_rd;
    logic cmd_exec;
    logic tick_inc;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_is_tick;
    logic scan_last;
  } dp_status_t;

endpackage

[rtl/core/tdst_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module tdst_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tdst_ctrl.sv]
// command sequencer for the task delay state table
`timescale 1ns / 1ps

module tdst_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  tdst_pkg::dp_status_t  status_i,
  output tdst_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CRD,
    ST_CEX,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.cmd_ld   = accept;
    cmd_o.scan_clr = accept;
    unique case (state_q)
      ST_SCAN:  cmd_o.scan_rd  = 1'b1;
      ST_DRAIN: cmd_o.tick_inc = 1'b1;
      ST_CRD:   cmd_o.cmd_rd   = 1'b1;
      ST_CEX:   cmd_o.cmd_exec = 1'b1;
      ST_OUT:   cmd_o.load_out = slot_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_OUT) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= status_i.in_is_tick ? ST_SCAN : ST_CRD;
          end
        end
        ST_SCAN: begin
          if (status_i.scan_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: state_q <= ST_OUT;
        ST_CRD:   state_q <= ST_CEX;
        ST_CEX:   state_q <= ST_OUT;
        ST_OUT: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/tdst_dp.sv]
// datapath: task table, scan counter, millisecond counter and result register
`timescale 1ns / 1ps

module tdst_dp #(
  parameter int NUM_TASKS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tdst_pkg::IN_W-1:0]     in_data_i,
  output logic [tdst_pkg::OUT_W-1:0]    out_data_o,
  input  tdst_pkg::ctrl_cmd_t           cmd_i,
  output tdst_pkg::dp_status_t          status_o
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W = $clog2(NUM_TASKS + 1);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_TASKS - 1);

  logic [tdst_pkg::CMD_W-1:0]    cmd_q;
  logic [tdst_pkg::TASK_W-1:0]   task_q;
  logic [tdst_pkg::NSTATE_W-1:0] nstate_q;
  logic [tdst_pkg::TIME_W-1:0]   len_q;

  logic [CNT_W-1:0]              scan_q;
  logic                          eval_v_q;
  logic [IDX_W-1:0]              eval_idx_q;
  logic [NUM_TASKS-1:0]          valid_q;
  logic                          rd_valid_q;
  logic [tdst_pkg::TIME_W-1:0]   tick_q;
  logic [tdst_pkg::STATE_W-1:0]  result_q;
  logic [tdst_pkg::STATE_W-1:0]  out_state_q;
  logic [tdst_pkg::TIME_W-1:0]   out_time_q;

  logic [IDX_W-1:0]              task_addr;
  logic [IDX_W-1:0]              rd_addr;
  logic [tdst_pkg::ENTRY_W-1:0]  rdata;
  logic [tdst_pkg::STATE_W-1:0]  ent_st;
  logic [tdst_pkg::TIME_W-1:0]   ent_wk;
  logic                          delaying;
  logic                          in_range;
  logic [tdst_pkg::STATE_W-1:0]  new_st;
  logic [tdst_pkg::TIME_W-1:0]   new_wk;
  logic                          wake_hit;
  logic                          we;
  logic [IDX_W-1:0]              waddr;
  logic [tdst_pkg::ENTRY_W-1:0]  wdata;

  assign task_addr = IDX_W'(task_q);
  assign rd_addr   = cmd_i.scan_rd ? scan_q[IDX_W-1:0] : task_addr;
  assign in_range  = ({28'd0, task_q} < 32'(NUM_TASKS));

  assign ent_st   = rd_valid_q ? rdata[tdst_pkg::STATE_W-1:0] : '0;
  assign ent_wk   = rd_valid_q ? rdata[tdst_pkg::ENTRY_W-1:tdst_pkg::STATE_W] : '0;
  assign delaying = (ent_st & tdst_pkg::FLAG_DELAYING) != '0;
  assign wake_hit = eval_v_q && delaying && (ent_wk == tick_q);

  always_comb begin
    new_st = ent_st;
    new_wk = ent_wk;
    case (cmd_q)
      tdst_pkg::CMD_MARK_INSTATE: begin
        if (!delaying) begin
          new_st = ent_st | tdst_pkg::FLAG_INSTATE;
        end
      end
      tdst_pkg::CMD_GOTO: begin
        if (!delaying) begin
          new_st = {2'b00, nstate_q};
        end
      end
      tdst_pkg::CMD_GOTO_FORCED: new_st = {2'b00, nstate_q};
      tdst_pkg::CMD_DELAY: begin
        if (!delaying) begin
          new_st = {2'b00, nstate_q} | tdst_pkg::FLAG_DELAYING;
          new_wk = len_q + tick_q;
        end
      end
      tdst_pkg::CMD_DELAY_FORCED: begin
        new_st = {2'b00, nstate_q} | tdst_pkg::FLAG_DELAYING;
        new_wk = len_q + tick_q;
      end
      default: ;
    endcase
  end

  // scan write-back has priority; the two never overlap
  always_comb begin
    if (eval_v_q) begin
      we    = wake_hit;
      waddr = eval_idx_q;
      wdata = {{tdst_pkg::TIME_W{1'b0}}, ent_st & ~tdst_pkg::FLAG_MASK};
    end else begin
      we    = cmd_i.cmd_exec && in_range;
      waddr = task_addr;
      wdata = {new_wk, new_st};
    end
  end

  tdst_ram #(
    .WIDTH (tdst_pkg::ENTRY_W),
    .DEPTH (NUM_TASKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= '0;
      eval_v_q <= 1'b0;
      valid_q  <= '0;
      tick_q   <= '0;
    end else begin
      eval_v_q <= cmd_i.scan_rd;
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.scan_rd) begin
        scan_q <= scan_q + 1'b1;
      end
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (cmd_i.tick_inc) begin
        tick_q <= tick_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd_ld) begin
      cmd_q    <= in_data_i[2:0];
      task_q   <= in_data_i[6:3];
      nstate_q <= in_data_i[12:7];
      len_q    <= in_data_i[28:13];
    end
    eval_idx_q <= rd_addr;
    rd_valid_q <= valid_q[rd_addr];
    if (cmd_i.tick_inc) begin
      result_q <= '0;
    end else if (cmd_i.cmd_exec) begin
      result_q <= in_range ? new_st : '0;
    end
    if (cmd_i.load_out) begin
      out_state_q <= result_q;
      out_time_q  <= tick_q;
    end
  end

  assign status_o.in_is_tick = (in_data_i[2:0] == tdst_pkg::CMD_TICK);
  assign status_o.scan_last  = (scan_q == LAST_IDX);
  assign out_data_o          = {out_time_q, out_state_q};

endmodule

[rtl/core/task_delay_state_table_core.sv]
// top level of the task delay state table
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: cmd, task_index, next_state, delay_length
//  m_axis    out  m_axis_tvalid/tready       tdata: task_state, time_now
//
// a tick scans the table one entry per cycle, then advances the counter and loads the output
// any other command steps through accept, table read, update and output load
// reset clears the table through per-entry valid bits, at once; the counter clears to zero
// a stalled output word holds the block in its last step until the slot is free;
// one word may wait in the output register while the next command is taken and worked
`timescale 1ns / 1ps

module task_delay_state_table_core #(
  parameter int NUM_TASKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // cmd [2:0], task_index [6:3], next_state [12:7], delay_length [28:13], zero [31:29]
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // task_state [7:0], time_now [23:8]
  output logic [23:0] m_axis_tdata_o
);

  tdst_pkg::ctrl_cmd_t  ctl;
  tdst_pkg::dp_status_t sts;

  tdst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (sts),
    .cmd_o       (ctl)
  );

  tdst_dp #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata_i),
    .out_data_o (m_axis_tdata_o),
    .cmd_i      (ctl),
    .status_o   (sts)
  );

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load_out |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("output word overwritten before it was taken");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken again while a command is in progress");

  a_tick_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.tick_inc |-> $past(ctl.scan_rd))
    else $error("counter advanced without a completed scan");

  a_one_read_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.scan_rd |-> (!ctl.cmd_rd && !ctl.cmd_exec && !s_axis_tready_o))
    else $error("table scan overlaps a command access");
`endif

endmodule
